@@ rtl/utf8_validating_decoder_core_defines.svh @@
// Assertion macros for the checker file of the decoder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef UTF8_VALIDATING_DECODER_CORE_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/utf8d_pkg.sv @@
`default_nettype none

package utf8d_pkg;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;

  // Bytes of an open sequence that can be held (lead plus two continuations).
  localparam int unsigned HOLD_DEPTH = 3;
  localparam int unsigned HOLD_IDX_W = $clog2(HOLD_DEPTH);

  // Command queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Result kinds as seen on the output channel.
  typedef enum logic [1:0] {
    KIND_VALID   = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // What the newest byte contributes after any flushed bytes.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_VALID,
    TAIL_INVALID,
    TAIL_END
  } tail_e;

  // One command: flushed held bytes, then an optional tail result.
  typedef struct packed {
    logic [HOLD_IDX_W-1:0]             flush_n;
    logic [HOLD_DEPTH-1:0][BYTE_W-1:0] flush_bytes;
    tail_e                             tail;
    logic [CP_W-1:0]                   value;
    logic [CNT_W-1:0]                  byte_count;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    kind_e             kind;
    logic [CP_W-1:0]   value;
    logic [CNT_W-1:0]  byte_count;
    logic              might_decompose;
    logic              might_combine;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/utf8d_byte_if.sv @@
`default_nettype none

interface utf8d_byte_if import utf8d_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8d_result_if.sv @@
`default_nettype none

interface utf8d_result_if import utf8d_pkg::*;;
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [CP_W-1:0]  value;
  logic [CNT_W-1:0] byte_count;
  logic             might_decompose;
  logic             might_combine;
  logic             last;

  modport source (
    output valid, output kind, output value, output byte_count,
    output might_decompose, output might_combine, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input value, input byte_count,
    input might_decompose, input might_combine, input last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/utf8_validating_decoder_core.sv @@
// Channel   Dir  Payload                                            Handshake
// byte_i    in   byte_in[7:0]                                       valid/ready
// result_o  out  kind, value[20:0], byte_count[2:0], might_decompose, valid/ready
//                might_combine, last
//
// One byte is accepted per cycle while the command queue has room; the back end sends
// one result beat per cycle while result_o is ready (up to four after a flush).
// The front classifies a byte in its accept cycle; a two-entry command queue
// and the registered output stage decouple it from result_o stalls.
// Results are registered in the command queue and then in the output register.
// Reset is asynchronous, active low, and empties the queue and the held bytes.

`default_nettype none

module utf8_validating_decoder_core import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  utf8d_byte_if.sink     byte_i,
  utf8d_result_if.source result_o
);

  logic    front_valid, front_ready;
  cmd_t    front_cmd;
  logic    back_valid, back_ready;
  cmd_t    back_cmd;
  logic    res_valid;
  result_t res;

  // Byte classification and sequence tracking.
  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_i.valid),
    .byte_i       (byte_i.byte_in),
    .byte_ready_o (byte_i.ready),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  // Command queue between front and back.
  utf8d_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  // Result sequencing and output register.
  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (res_valid),
    .out_ready_i (result_o.ready),
    .out_o       (res)
  );

  assign result_o.valid           = res_valid;
  assign result_o.kind            = res.kind;
  assign result_o.value           = res.value;
  assign result_o.byte_count      = res.byte_count;
  assign result_o.might_decompose = res.might_decompose;
  assign result_o.might_combine   = res.might_combine;
  assign result_o.last            = res.last;

endmodule

`default_nettype wire

@@ rtl/utf8d_front.sv @@
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              byte_ready_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  // Length of the sequence opened by a lead byte, zero if it opens none.
  function automatic logic [CNT_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] len;
    len = 3'd0;
    if (b inside {[8'hC2:8'hDF]}) begin
      len = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      len = 3'd3;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Extra range rules on the byte right after the E0, F0 and F4 leads.
  function automatic logic second_ok(input logic [BYTE_W-1:0] lead,
                                     input logic [BYTE_W-1:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == 8'hE0 && b <= 8'h9F) ok = 1'b0;
    if (lead == 8'hF0 && b <= 8'h8F) ok = 1'b0;
    if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
    return ok;
  endfunction

  logic [HOLD_DEPTH-1:0][BYTE_W-1:0] held_q, held_d;
  logic [HOLD_IDX_W-1:0]             held_n_q, held_n_d;

  logic [BYTE_W-1:0] lead;
  logic [CNT_W-1:0]  need;
  logic              ext_ok;
  logic              complete;
  logic              accept;
  cmd_t              cmd;

  assign lead = held_q[0];
  assign need = seq_len(lead);

  // The new byte extends the open sequence if it is a continuation byte
  // that also obeys the second-byte rule.
  assign ext_ok = (held_n_q != '0) && (byte_i[7:6] == 2'b10)
                  && ((held_n_q != 2'd1) || second_ok(lead, byte_i));
  assign complete = ext_ok && (({1'b0, held_n_q} + 3'd1) == need);

  // Classify the byte against the held bytes and build the command.
  always_comb begin
    held_d          = held_q;
    held_n_d        = held_n_q;
    cmd.flush_n     = '0;
    cmd.flush_bytes = held_q;
    cmd.tail        = TAIL_NONE;
    cmd.value       = CP_W'(byte_i);
    cmd.byte_count  = 3'd1;
    if (ext_ok) begin
      if (complete) begin
        cmd.tail       = TAIL_VALID;
        cmd.byte_count = need;
        held_n_d       = '0;
        case (need)
          3'd2: cmd.value = CP_W'({lead[4:0], byte_i[5:0]});
          3'd3: cmd.value = CP_W'({lead[3:0], held_q[1][5:0], byte_i[5:0]});
          default: cmd.value = {lead[2:0], held_q[1][5:0], held_q[2][5:0], byte_i[5:0]};
        endcase
      end else begin
        held_d[held_n_q] = byte_i;
        held_n_d         = held_n_q + 2'd1;
      end
    end else begin
      // A broken sequence flushes every held byte, then the byte starts anew.
      cmd.flush_n = held_n_q;
      held_n_d    = '0;
      if (byte_i == '0) begin
        cmd.tail       = TAIL_END;
        cmd.value      = '0;
        cmd.byte_count = '0;
      end else if (!byte_i[7]) begin
        cmd.tail = TAIL_VALID;
      end else if (seq_len(byte_i) != '0) begin
        held_d[0] = byte_i;
        held_n_d  = 2'd1;
      end else begin
        cmd.tail = TAIL_INVALID;
      end
    end
  end

  assign byte_ready_o = cmd_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign cmd_valid_o  = byte_valid_i && ((cmd.flush_n != '0) || (cmd.tail != TAIL_NONE));
  assign cmd_o        = cmd;

  // Count of held bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_n_q <= '0;
    end else if (accept) begin
      held_n_q <= held_n_d;
    end
  end

  // Held byte storage.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8d_cmd_fifo.sv @@
`default_nettype none

module utf8d_cmd_fifo import utf8d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8d_back.sv @@
`default_nettype none

module utf8d_back import utf8d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  // Range gate of the decomposition table.
  function automatic logic gate_decompose(input logic [CP_W-1:0] cp);
    logic hit;
    hit = (cp >= 21'h0000A0);
    if (cp > 21'h0033FF && (cp < 21'h00A69C || (cp < 21'h00F900 && cp > 21'h00AB5F))) begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  // Range gate of the combining-class table.
  function automatic logic gate_combine(input logic [CP_W-1:0] cp);
    logic hit;
    hit = (cp >= 21'h000300);
    if (cp > 21'h00309A && (cp < 21'h00A66F || (cp < 21'h00FB1E && cp > 21'h00ABED))) begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  logic [HOLD_IDX_W-1:0] idx_q;
  logic [HOLD_IDX_W-1:0] last_idx;
  logic                  final_item;
  logic                  load;
  logic                  out_valid_q;
  result_t               res_q, res_d;

  // Beat index of the final result of the current command.
  assign last_idx   = cmd_i.flush_n - ((cmd_i.tail == TAIL_NONE) ? 2'd1 : 2'd0);
  assign final_item = (idx_q == last_idx);
  assign load       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = load && final_item;

  // Pick the flushed byte or the tail result for this beat.
  always_comb begin
    res_d.last = final_item;
    if (idx_q < cmd_i.flush_n) begin
      res_d.kind       = KIND_INVALID;
      res_d.value      = CP_W'(cmd_i.flush_bytes[idx_q]);
      res_d.byte_count = 3'd1;
    end else begin
      res_d.value      = cmd_i.value;
      res_d.byte_count = cmd_i.byte_count;
      case (cmd_i.tail)
        TAIL_VALID: res_d.kind = KIND_VALID;
        TAIL_END:   res_d.kind = KIND_END;
        default:    res_d.kind = KIND_INVALID;
      endcase
    end
    res_d.might_decompose = (res_d.kind == KIND_VALID) && gate_decompose(res_d.value);
    res_d.might_combine   = (res_d.kind == KIND_VALID) && gate_combine(res_d.value);
  end

  // Beat index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= final_item ? '0 : idx_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/utf8d_checker.sv @@
`default_nettype none

`include "utf8_validating_decoder_core_defines.svh"

module utf8d_checker import utf8d_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [BYTE_W-1:0] in_byte_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       out_kind_i,
  input logic [CP_W-1:0]  out_value_i,
  input logic [CNT_W-1:0] out_count_i,
  input logic             out_dec_i,
  input logic             out_comb_i,
  input logic             out_last_i
);

  // An invalid beat carries one raw byte of 80-FF and no gate flags.
  `UTF8D_ASSERT_NOW(a_invalid_shape, out_valid_i && out_kind_i == KIND_INVALID, out_count_i == 3'd1 && out_value_i[20:8] == '0 && out_value_i[7] && !out_dec_i && !out_comb_i, "invalid beat is malformed")

  // The end beat is empty and always closes the results of its byte.
  `UTF8D_ASSERT_NOW(a_end_shape, out_valid_i && out_kind_i == KIND_END, out_value_i == '0 && out_count_i == '0 && out_last_i, "end beat is malformed")

  // A one-byte codepoint is ASCII; longer ones are not.
  `UTF8D_ASSERT_NOW(a_valid_len, out_valid_i && out_kind_i == KIND_VALID, (out_count_i == 3'd1) == (out_value_i < 21'h80) && out_count_i != '0, "codepoint length disagrees with value")

  // A stalled result beat holds.
  `UTF8D_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i) && $stable(out_kind_i) && $stable(out_last_i), "stalled result changed")

  // An accepted byte never carries unknown bits.
  `UTF8D_ASSERT_NOW(a_in_known, in_valid_i && in_ready_i, !$isunknown(in_byte_i), "accepted byte is unknown")

endmodule

bind utf8_validating_decoder_core utf8d_checker u_utf8d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_byte_i   (byte_i.byte_in),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_kind_i  (result_o.kind),
  .out_value_i (result_o.value),
  .out_count_i (result_o.byte_count),
  .out_dec_i   (result_o.might_decompose),
  .out_comb_i  (result_o.might_combine),
  .out_last_i  (result_o.last)
);

`default_nettype wire
